FILE: rtl/core/rea_pkg.sv
`default_nettype none

package rea_pkg;

  // Field widths of the block's beats
  localparam int unsigned ModW   = 16;  // counts_per_turn, preset, position
  localparam int unsigned AngleW = 12;  // angle in tenths of a degree
  localparam int unsigned ProdW  = ModW + AngleW;

  localparam logic [AngleW-1:0] FullTurnTenths       = 12'd3600;
  localparam logic [ModW-1:0]   DefaultCountsPerTurn = 16'd5000;

  typedef enum logic {
    OP_EDGE   = 1'b0,
    OP_PRESET = 1'b1
  } rea_op_e;

  // Control of the shared serial divide unit
  typedef struct packed {
    logic load;
    logic step;
  } rea_div_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/rea_if.sv
`default_nettype none

interface rea_in_if import rea_pkg::*;;
  logic            valid;
  logic            ready;
  logic [0:0]      opcode;
  logic [0:0]      b_level;
  logic [ModW-1:0] preset_value;

  modport source (output valid, output opcode, output b_level, output preset_value,
                  input ready);
  modport sink   (input valid, input opcode, input b_level, input preset_value,
                  output ready);
endinterface

interface rea_out_if import rea_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ModW-1:0]   position;
  logic [AngleW-1:0] angle_tenths;
  logic [0:0]        preset_rejected;

  modport source (output valid, output position, output angle_tenths,
                  output preset_rejected, input ready);
  modport sink   (input valid, input position, input angle_tenths,
                  input preset_rejected, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rea_serdiv.sv
`default_nettype none

// Restoring divide, one quotient bit per step. The remainder starts below
// the divisor; numerator bits shift in MSB first.
module rea_serdiv import rea_pkg::*; #(
  parameter int unsigned NumW = 16
) (
  input  wire logic                clk_i,
  input  wire rea_div_ctrl_t       ctrl_i,
  input  wire logic [ModW-1:0]     rem_init_i,
  input  wire logic [NumW-1:0]     num_i,
  input  wire logic [ModW-1:0]     divisor_i,
  output logic      [ModW-1:0]     rem_o,
  output logic      [AngleW-1:0]   quo_o
);

  logic [ModW-1:0]   rem_q, rem_d;
  logic [NumW-1:0]   num_q, num_d;
  logic [AngleW-1:0] quo_q, quo_d;
  logic [ModW:0]     trial;
  logic [ModW:0]     diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, num_q[NumW-1]};
    ge    = trial >= {1'b0, divisor_i};
    diff  = trial - {1'b0, divisor_i};
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      rem_d = rem_init_i;
      num_d = num_i;
      quo_d = '0;
    end else if (ctrl_i.step) begin
      rem_d = ge ? diff[ModW-1:0] : trial[ModW-1:0];
      num_d = {num_q[NumW-2:0], 1'b0};
      quo_d = {quo_q[AngleW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/rotary_encoder_angle.sv
`default_nettype none

// Single-edge quadrature position counter with angle readout. Each input beat
// is either a rising edge of channel A (b_level high counts up, low counts
// down) or a preset; every beat yields one result beat with the position, the
// angle in tenths of a degree (position*3600/counts_per_turn, truncated, held
// at 3600 when the position is at or past a full turn) and a flag for a preset
// above counts_per_turn, which leaves the position alone. Positions wrap into
// 0..counts_per_turn inclusive. One item is worked at a time: a beat whose
// position ends at or past a full turn (or with counts_per_turn of zero) skips
// the multiply and divide, and with counts_per_turn of zero the angle is 0. A
// single shared restoring divide unit retires one bit per cycle, first for the
// wrap remainder (COUNT_WIDTH steps) of a beat that wraps and then for the
// angle (12 steps), behind a 12-step shift-add multiply by 3600. A finished
// result waits in an output register, so the next beat can be taken and worked
// while the previous result is still unclaimed; a further result that finds it
// full waits, and no new beat is taken meanwhile.
// counts_per_turn is written through cfg_we_i/cfg_wdata_i and resets to 5000.
// The user must write it only while idle; the block itself does not enforce it.
module rotary_encoder_angle import rea_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [ModW-1:0] cfg_wdata_i,
  rea_in_if.sink               in_i,
  rea_out_if.source            out_o
);

  // Compare width that holds the count, the modulus and count + 1
  localparam int unsigned CmpW = ((COUNT_WIDTH > ModW) ? COUNT_WIDTH : ModW) + 1;
  // Numerator shift width of the divide unit
  localparam int unsigned NumW = (COUNT_WIDTH > AngleW) ? COUNT_WIDTH : AngleW;
  localparam int unsigned CntW = $clog2(NumW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a beat
  localparam logic [2:0] ST_MOD  = 3'd1;  // wrap remainder, one bit a cycle
  localparam logic [2:0] ST_FIX  = 3'd2;  // store remainder + 1
  localparam logic [2:0] ST_ANG  = 3'd3;  // pick the angle path
  localparam logic [2:0] ST_MUL  = 3'd4;  // shift-add by 3600
  localparam logic [2:0] ST_DLD  = 3'd5;  // load the divide unit
  localparam logic [2:0] ST_DIV  = 3'd6;  // angle quotient, one bit a cycle
  localparam logic [2:0] ST_DONE = 3'd7;  // hand the result to the output register

  logic [2:0]             state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [ModW-1:0]        m_q, m_d;
  logic                   rej_q, rej_d;
  logic [AngleW-1:0]      angle_q, angle_d;
  logic                   use_quo_q, use_quo_d;
  logic [ProdW-1:0]       acc_q, acc_d;

  logic                   out_valid_q, out_valid_d;
  logic [ModW-1:0]        out_pos_q, out_pos_d;
  logic [AngleW-1:0]      out_ang_q, out_ang_d;
  logic                   out_rej_q, out_rej_d;

  logic                   in_fire;
  logic [CmpW-1:0]        count_ext;
  logic [CmpW-1:0]        m_ext;
  logic [CmpW-1:0]        up_v;
  logic [CmpW-1:0]        dn_v;
  logic [ModW-1:0]        m_minus;
  logic [COUNT_WIDTH-1:0] mod_x;
  logic [ModW:0]          rem_plus;
  logic [3:0]             mul_idx;

  rea_div_ctrl_t          div_ctrl;
  logic [ModW-1:0]        div_rem_init;
  logic [NumW-1:0]        div_num;
  logic [ModW-1:0]        div_rem;
  logic [AngleW-1:0]      div_quo;

  assign in_fire   = in_i.valid && in_i.ready;
  assign count_ext = CmpW'(count_q);
  assign m_ext     = CmpW'(m_q);
  assign up_v      = count_ext + CmpW'(1);
  assign dn_v      = count_ext - CmpW'(1);
  assign m_minus   = m_q - ModW'(1);
  assign rem_plus  = {1'b0, div_rem} + (ModW+1)'(1);
  assign mul_idx   = cnt_q[3:0] - 4'd1;

  // Wrap input: count for an up step, count - 2 for a down step
  assign mod_x = (in_i.b_level == 1'b1) ? count_q : count_q - COUNT_WIDTH'(2);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    count_d      = count_q;
    m_d          = m_q;
    rej_d        = rej_q;
    angle_d      = angle_q;
    use_quo_d    = use_quo_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q;
    out_pos_d    = out_pos_q;
    out_ang_d    = out_ang_q;
    out_rej_d    = out_rej_q;
    div_ctrl     = '0;
    div_rem_init = '0;
    div_num      = NumW'(mod_x) << (NumW - COUNT_WIDTH);

    if (cfg_we_i) begin
      m_d = cfg_wdata_i;
    end

    // Drop the result once the sink takes it
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rej_d   = 1'b0;
          state_d = ST_ANG;
          if (in_i.opcode == OP_PRESET) begin
            if (in_i.preset_value > m_q) begin
              rej_d = 1'b1;
            end else begin
              count_d = COUNT_WIDTH'(in_i.preset_value);
            end
          end else if (m_q == '0) begin
            count_d = '0;
          end else if (in_i.b_level == 1'b1) begin
            if (up_v > m_ext) begin
              div_ctrl.load = 1'b1;
              cnt_d         = CntW'(COUNT_WIDTH);
              state_d       = ST_MOD;
            end else begin
              count_d = up_v[COUNT_WIDTH-1:0];
            end
          end else if (count_q == '0) begin
            count_d = COUNT_WIDTH'(m_minus);
          end else if (dn_v > m_ext) begin
            div_ctrl.load = 1'b1;
            cnt_d         = CntW'(COUNT_WIDTH);
            state_d       = ST_MOD;
          end else begin
            count_d = dn_v[COUNT_WIDTH-1:0];
          end
        end
      end

      ST_MOD: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_FIX;
        end
      end

      ST_FIX: begin
        count_d = COUNT_WIDTH'(rem_plus);
        state_d = ST_ANG;
      end

      ST_ANG: begin
        use_quo_d = 1'b0;
        if (m_q == '0) begin
          angle_d = '0;
          state_d = ST_DONE;
        end else if (count_ext >= m_ext) begin
          angle_d = FullTurnTenths;
          state_d = ST_DONE;
        end else begin
          acc_d   = '0;
          cnt_d   = CntW'(AngleW);
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        // MSB first over the bits of 3600; count is below the modulus here
        acc_d = {acc_q[ProdW-2:0], 1'b0} +
                (FullTurnTenths[mul_idx] ? ProdW'(count_ext[ModW-1:0]) : ProdW'(0));
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_DLD;
        end
      end

      ST_DLD: begin
        // High part is below the modulus since the quotient fits 12 bits
        div_ctrl.load = 1'b1;
        div_rem_init  = acc_q[ProdW-1:AngleW];
        div_num       = NumW'(acc_q[AngleW-1:0]) << (NumW - AngleW);
        cnt_d         = CntW'(AngleW);
        state_d       = ST_DIV;
      end

      ST_DIV: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          use_quo_d = 1'b1;
          state_d   = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free or being emptied
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pos_d   = ModW'(count_q);
          out_ang_d   = use_quo_q ? div_quo : angle_q;
          out_rej_d   = rej_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  rea_serdiv #(
    .NumW (NumW)
  ) u_serdiv (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .rem_init_i (div_rem_init),
    .num_i      (div_num),
    .divisor_i  (m_q),
    .rem_o      (div_rem),
    .quo_o      (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      m_q         <= DefaultCountsPerTurn;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      m_q         <= m_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rej_q     <= rej_d;
    angle_q   <= angle_d;
    use_quo_q <= use_quo_d;
    acc_q     <= acc_d;
    out_pos_q <= out_pos_d;
    out_ang_q <= out_ang_d;
    out_rej_q <= out_rej_d;
  end

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.position        = out_pos_q;
  assign out_o.angle_tenths    = out_ang_q;
  assign out_o.preset_rejected = out_rej_q;

endmodule

`default_nettype wire
